// ===== sv/frm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants for the frequency rank matcher.
// ----------------------------------------------------------------------------
package frm_pkg;

	localparam int OP_W       = 2;
	localparam int PRINT_IN_W = 48;
	localparam int CNT_W      = 31;
	localparam int OUT_W      = 9;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD_TRAIN  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_TARGET = 2'd1;
	localparam logic [OP_W-1:0] OP_ANALYZE     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_WALK,
		ST_PUT,
		ST_COMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [OUT_W-1:0] unique_total;
		logic [OUT_W-1:0] involved_total;
		logic [OUT_W-1:0] correct_total;
	} res_t;

endpackage

// ===== sv/frequency_rank_matcher.sv =====
`timescale 1ns / 1ps
// Load beat: written directly into an empty store, otherwise placed by a walk from the tail.
// Full store: a tail check state comes first; a drop ends there, an eviction walks
// at most CAPACITY-1 ranks.
// Analyze beat: ranks are compared in turn (ST_COMP), then the result is registered (ST_OUT).
// One item at a time; the block stalls its input while a walk runs on the store RAM port.
// Async reset empties both stores at once (fill counts only) and drops any pending result.
// ----------------------------------------------------------------------------
// frequency_rank_matcher
// Two ranked top-CAPACITY stores (training, target) and a rank-by-rank matcher.
// ----------------------------------------------------------------------------
module frequency_rank_matcher #(
	parameter int CAPACITY    = 256,
	parameter int PRINT_BYTES = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [frm_pkg::OP_W-1:0]       operation,
	input  logic [frm_pkg::PRINT_IN_W-1:0] fingerprint,
	input  logic [frm_pkg::CNT_W-1:0]      occurrences,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [frm_pkg::OUT_W-1:0]      unique_total,
	output logic [frm_pkg::OUT_W-1:0]      involved_total,
	output logic [frm_pkg::OUT_W-1:0]      correct_total
);
	import frm_pkg::*;

	localparam int PW     = 8 * PRINT_BYTES;
	localparam int KEEP_W = (PW < PRINT_IN_W) ? PW : PRINT_IN_W;
	localparam int EW     = KEEP_W + CNT_W;
	localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic          trn_we, tgt_we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, trn_rdata, tgt_rdata;
	logic          res_load, out_busy;
	res_t          res;
	logic          out_valid_q;
	res_t          out_q;

	frm_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(AW)) u_train_ram (
		.clk   (clk),
		.we    (trn_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (trn_rdata)
	);

	frm_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(AW)) u_target_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (tgt_rdata)
	);

	frm_seq #(.CAPACITY(CAPACITY), .KEEP_W(KEEP_W), .AW(AW), .EW(EW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.in_print  (fingerprint[KEEP_W-1:0]),
		.in_count  (occurrences),
		.trn_we    (trn_we),
		.tgt_we    (tgt_we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.trn_rdata (trn_rdata),
		.tgt_rdata (tgt_rdata),
		.out_busy  (out_busy),
		.res_load  (res_load),
		.res       (res)
	);

	// result register: loads keep flowing while a result waits
	assign out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign unique_total   = out_q.unique_total;
	assign involved_total = out_q.involved_total;
	assign correct_total  = out_q.correct_total;

endmodule

// ===== sv/frm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module frm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/frm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_seq
// Sequencer for ranked insertion and rank-by-rank comparison. One count
// comparator is reused through every walk, one print comparator through every compare.
// ----------------------------------------------------------------------------
module frm_seq #(
	parameter int CAPACITY = 256,
	parameter int KEEP_W   = 48,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int EW       = KEEP_W + frm_pkg::CNT_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [frm_pkg::OP_W-1:0]  operation,
	input  logic [KEEP_W-1:0]         in_print,
	input  logic [frm_pkg::CNT_W-1:0] in_count,
	output logic                      trn_we,
	output logic                      tgt_we,
	output logic [AW-1:0]             waddr,
	output logic [EW-1:0]             wdata,
	output logic [AW-1:0]             raddr,
	input  logic [EW-1:0]             trn_rdata,
	input  logic [EW-1:0]             tgt_rdata,
	input  logic                      out_busy,
	output logic                      res_load,
	output frm_pkg::res_t             res
);
	import frm_pkg::*;

	localparam int FW = $clog2(CAPACITY + 1);
	localparam logic [FW-1:0] CAP_F    = FW'(CAPACITY);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

	state_t            state_q, state_d;
	logic              sel_q;
	logic [KEEP_W-1:0] print_q;
	logic [CNT_W-1:0]  count_q;
	logic [AW-1:0]     idx_q;
	logic [FW-1:0]     train_fill_q, target_fill_q;
	logic [FW-1:0]     rd_idx_q, inv_q, correct_q;

	logic              in_acc;
	logic [FW-1:0]     op_fill, fill_min;
	logic              op_full, is_load;
	logic [EW-1:0]     sel_rdata;
	logic [CNT_W-1:0]  rd_count;
	logic              cnt_gt, print_eq, we;
	logic              cur_sel;

	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign op_fill   = operation[0] ? target_fill_q : train_fill_q;
	assign op_full   = (op_fill == CAP_F);
	assign is_load   = (operation == OP_LOAD_TRAIN) || (operation == OP_LOAD_TARGET);
	assign fill_min  = (train_fill_q < target_fill_q) ? train_fill_q : target_fill_q;
	assign sel_rdata = sel_q ? tgt_rdata : trn_rdata;
	assign rd_count  = sel_rdata[CNT_W-1:0];
	// shared count compare: new count strictly above the stored one
	assign cnt_gt    = (count_q > rd_count);
	assign print_eq  = (trn_rdata[EW-1:CNT_W] == tgt_rdata[EW-1:CNT_W]);
	assign cur_sel   = (state_q == ST_IDLE) ? operation[0] : sel_q;
	assign trn_we    = we && !cur_sel;
	assign tgt_we    = we && cur_sel;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (operation) inside
						OP_LOAD_TRAIN, OP_LOAD_TARGET: begin
							if (op_full) begin
								state_d = ST_CHK;
							end else if (op_fill != '0) begin
								state_d = ST_WALK;
							end
						end
						OP_ANALYZE: begin
							state_d = (fill_min == '0) ? ST_OUT : ST_COMP;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CHK: begin
				if (!cnt_gt) begin
					state_d = ST_IDLE;
				end else begin
					state_d = (LAST_IDX == '0) ? ST_PUT : ST_WALK;
				end
			end
			ST_WALK: begin
				if (!cnt_gt) begin
					state_d = ST_IDLE;
				end else if (idx_q == AW'(1)) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT:  state_d = ST_IDLE;
			ST_COMP: begin
				if (rd_idx_q == inv_q) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: memory control, handshake, result load
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		we       = 1'b0;
		waddr    = idx_q;
		wdata    = {print_q, count_q};
		raddr    = '0;
		res_load = 1'b0;
		res.unique_total   = OUT_W'(target_fill_q);
		res.involved_total = OUT_W'(inv_q);
		res.correct_total  = OUT_W'(correct_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_load) begin
					if (op_full) begin
						raddr = LAST_IDX;
					end else if (op_fill == '0) begin
						we    = 1'b1;
						waddr = '0;
						wdata = {in_print, in_count};
					end else begin
						raddr = op_fill[AW-1:0] - AW'(1);
					end
				end
			end
			ST_CHK: begin
				raddr = LAST_IDX - AW'(1);
			end
			ST_WALK: begin
				we = 1'b1;
				if (cnt_gt) begin
					// shift the held entry one rank down
					wdata = sel_rdata;
					raddr = idx_q - AW'(2);
				end
			end
			ST_PUT: we = 1'b1;
			ST_COMP: raddr = rd_idx_q[AW-1:0];
			ST_OUT:  res_load = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			train_fill_q  <= '0;
			target_fill_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc && is_load && !op_full) begin
				if (operation[0]) begin
					target_fill_q <= target_fill_q + FW'(1);
				end else begin
					train_fill_q <= train_fill_q + FW'(1);
				end
			end
			if (state_q == ST_OUT && !out_busy) begin
				train_fill_q  <= '0;
				target_fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sel_q     <= operation[0];
				print_q   <= in_print;
				count_q   <= in_count;
				idx_q     <= op_fill[AW-1:0];
				inv_q     <= fill_min;
				rd_idx_q  <= FW'(1);
				correct_q <= '0;
			end
			ST_CHK:  idx_q <= LAST_IDX;
			ST_WALK: begin
				if (cnt_gt) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			ST_COMP: begin
				rd_idx_q  <= rd_idx_q + FW'(1);
				correct_q <= correct_q + FW'(print_eq);
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/frm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_checker
// Port-level checks for the frequency rank matcher, bound to the top level.
// ----------------------------------------------------------------------------
module frm_checker #(
	parameter int CAPACITY = 256
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [frm_pkg::OP_W-1:0]       operation,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [frm_pkg::OUT_W-1:0]      unique_total,
	input logic [frm_pkg::OUT_W-1:0]      involved_total,
	input logic [frm_pkg::OUT_W-1:0]      correct_total
);
	import frm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(unique_total) && $stable(involved_total)
			&& $stable(correct_total))
		else $error("stalled result changed");

	// an accepted analyze beat always moves the sequencer out of idle, so in_stall rises after it
	a_analyze_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_ANALYZE |=> in_stall)
		else $error("analyze beat did not hold off the input");

	generate
		if (CAPACITY < 512) begin : g_order
			a_totals: assert property (@(posedge clk) disable iff (!arst_n)
				out_valid |-> correct_total <= involved_total
					&& involved_total <= unique_total)
				else $error("result totals out of order");
		end
	endgenerate

endmodule

bind frequency_rank_matcher frm_checker #(.CAPACITY(CAPACITY)) u_frm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.operation      (operation),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.unique_total   (unique_total),
	.involved_total (involved_total),
	.correct_total  (correct_total)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frequency rank matcher: loads ranked training
// and target sets, predicts the analyze totals and checks every result beat.
// ----------------------------------------------------------------------------
module tb;

	import frm_pkg::*;

	localparam int CAPACITY    = 256;
	localparam int PRINT_BYTES = 6;
	localparam int KEPT_BITS   = (8 * PRINT_BYTES < PRINT_IN_W) ? 8 * PRINT_BYTES : PRINT_IN_W;
	localparam logic [PRINT_IN_W-1:0] PRINT_MASK = {PRINT_IN_W{1'b1}} >> (PRINT_IN_W - KEPT_BITS);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [PRINT_IN_W-1:0] PRINT_MAX = {PRINT_IN_W{1'b1}};
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int TRAIN_SIDE  = 0;
	localparam int TARGET_SIDE = 1;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [OP_W-1:0]       op;
		logic [PRINT_IN_W-1:0] fp;
		logic [CNT_W-1:0]      cnt;
	} beat_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       operation   = '0;
	logic [PRINT_IN_W-1:0] fingerprint = '0;
	logic [CNT_W-1:0]      occurrences = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [OUT_W-1:0]      unique_total;
	logic [OUT_W-1:0]      involved_total;
	logic [OUT_W-1:0]      correct_total;

	frequency_rank_matcher #(
		.CAPACITY(CAPACITY),
		.PRINT_BYTES(PRINT_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.fingerprint(fingerprint),
		.occurrences(occurrences),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.unique_total(unique_total),
		.involved_total(involved_total),
		.correct_total(correct_total)
	);

	// ranked stores as the block should hold them, index 0 training, 1 target
	logic [PRINT_IN_W-1:0] held_print [2][CAPACITY];
	logic [CNT_W-1:0]      held_count [2][CAPACITY];
	int                    held_fill [2] = '{0, 0};

	beat_t pending_beats [$];
	res_t  due_totals [$];
	beat_t next_beat;
	res_t  want;
	logic [PRINT_IN_W-1:0] set_prints [4];

	int beats_outstanding = 0;
	int beats_queued      = 0;
	int analyzes_queued   = 0;
	int failures          = 0;
	int send_gap          = 0;
	int recv_gap          = 0;
	bit send_idle         = 1'b1;
	bit recv_idle         = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	task automatic rank_insert(input int side, input logic [PRINT_IN_W-1:0] fp,
			input logic [CNT_W-1:0] cnt);
		int pos;
		int last;
		bit keep;
		keep = 1'b1;
		if (held_fill[side] == CAPACITY) begin
			// full: only a strictly larger count evicts the tail entry
			if (cnt > held_count[side][CAPACITY-1])
				last = CAPACITY - 1;
			else
				keep = 1'b0;
		end else begin
			last = held_fill[side];
			held_fill[side]++;
		end
		if (keep) begin
			pos = 0;
			while (pos < last && held_count[side][pos] >= cnt)
				pos++;
			for (int k = last; k > pos; k--) begin
				held_print[side][k] = held_print[side][k-1];
				held_count[side][k] = held_count[side][k-1];
			end
			held_print[side][pos] = fp;
			held_count[side][pos] = cnt;
		end
	endtask

	task automatic track_beat(input logic [OP_W-1:0] op, input logic [PRINT_IN_W-1:0] fp,
			input logic [CNT_W-1:0] cnt);
		int involved;
		int correct;
		res_t r;
		case (op)
			OP_LOAD_TRAIN: rank_insert(TRAIN_SIDE, fp & PRINT_MASK, cnt);
			OP_LOAD_TARGET: rank_insert(TARGET_SIDE, fp & PRINT_MASK, cnt);
			OP_ANALYZE: begin
				involved = (held_fill[TRAIN_SIDE] < held_fill[TARGET_SIDE]) ?
					held_fill[TRAIN_SIDE] : held_fill[TARGET_SIDE];
				correct = 0;
				for (int i = 0; i < involved; i++)
					if (held_print[TRAIN_SIDE][i] == held_print[TARGET_SIDE][i])
						correct++;
				r.unique_total   = OUT_W'(held_fill[TARGET_SIDE]);
				r.involved_total = OUT_W'(involved);
				r.correct_total  = OUT_W'(correct);
				due_totals.push_back(r);
				held_fill[TRAIN_SIDE]  = 0;
				held_fill[TARGET_SIDE] = 0;
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				track_beat(operation, fingerprint, occurrences);
				beats_outstanding--;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0 || pending_beats.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					in_valid <= 1'b0;
				end else begin
					next_beat = pending_beats.pop_front();
					operation   <= next_beat.op;
					fingerprint <= next_beat.fp;
					occurrences <= next_beat.cnt;
					in_valid    <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						send_idle = !send_idle;
					send_gap = send_idle ? $urandom_range(0, 4) : 0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_totals.size() == 0) begin
					$error("result beat with no analyze pending: unique_total=%0d involved_total=%0d correct_total=%0d",
						unique_total, involved_total, correct_total);
					failures++;
				end else begin
					want = due_totals.pop_front();
					if (unique_total !== want.unique_total) begin
						$error("unique_total: expected %0d, got %0d", want.unique_total, unique_total);
						failures++;
					end
					if (involved_total !== want.involved_total) begin
						$error("involved_total: expected %0d, got %0d", want.involved_total,
							involved_total);
						failures++;
					end
					if (correct_total !== want.correct_total) begin
						$error("correct_total: expected %0d, got %0d", want.correct_total,
							correct_total);
						failures++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					recv_idle = !recv_idle;
				recv_gap = recv_idle ? $urandom_range(0, 4) : 0;
			end else if (out_valid && recv_gap > 0) begin
				recv_gap--;
			end
			out_stall <= (recv_gap > 0);
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic void push_beat(input logic [OP_W-1:0] op,
			input logic [PRINT_IN_W-1:0] fp, input logic [CNT_W-1:0] cnt);
		beat_t b;
		b.op  = op;
		b.fp  = fp;
		b.cnt = cnt;
		pending_beats.push_back(b);
		beats_outstanding++;
		if (op != OP_UNUSED)
			beats_queued++;
		if (op == OP_ANALYZE)
			analyzes_queued++;
	endfunction

	function automatic logic [PRINT_IN_W-1:0] rand_print();
		return PRINT_IN_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [PRINT_IN_W-1:0] pick_print();
		if ($urandom_range(0, 3) != 0)
			return set_prints[$urandom_range(0, 3)];
		return rand_print();
	endfunction

	function automatic logic [CNT_W-1:0] pick_count(input bit ties);
		if (ties)
			return CNT_W'($urandom_range(0, 7));
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CNT_MAX;
			default: return CNT_W'($urandom());
		endcase
	endfunction

	// one training/target set followed by its analyze beat
	task automatic queue_set(input int n_train, input int n_target, input bit mirror,
			input bit ties);
		beat_t train_list [$];
		beat_t target_list [$];
		beat_t b;
		foreach (set_prints[i])
			set_prints[i] = rand_print();
		for (int i = 0; i < n_train; i++) begin
			b.op  = OP_LOAD_TRAIN;
			b.fp  = pick_print();
			b.cnt = pick_count(ties);
			train_list.push_back(b);
		end
		for (int i = 0; i < n_target; i++) begin
			// mirrored sets repeat the training sequence, so ranks mostly line up
			if (mirror && i < n_train && $urandom_range(0, 4) != 0) begin
				b = train_list[i];
			end else begin
				b.fp  = pick_print();
				b.cnt = pick_count(ties);
			end
			b.op = OP_LOAD_TARGET;
			target_list.push_back(b);
		end
		while (train_list.size() + target_list.size() > 0) begin
			if ($urandom_range(0, 19) == 0)
				push_beat(OP_UNUSED, rand_print(), CNT_W'($urandom()));
			if (target_list.size() == 0 || (train_list.size() > 0 && $urandom_range(0, 1)))
				b = train_list.pop_front();
			else
				b = target_list.pop_front();
			push_beat(b.op, b.fp, b.cnt);
		end
		push_beat(OP_ANALYZE, rand_print(), CNT_W'($urandom()));
	endtask

	task automatic wait_drained();
		while (beats_outstanding != 0 || due_totals.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty stores
		push_beat(OP_ANALYZE, '0, '0);
		// field extremes
		push_beat(OP_LOAD_TRAIN, '0, '0);
		push_beat(OP_LOAD_TRAIN, PRINT_MAX, CNT_MAX);
		push_beat(OP_LOAD_TARGET, PRINT_MAX, CNT_MAX);
		push_beat(OP_LOAD_TARGET, '0, '0);
		push_beat(OP_ANALYZE, PRINT_MAX, CNT_MAX);
		// unused code is ignored
		push_beat(OP_UNUSED, PRINT_MAX, CNT_MAX);
		// equal counts keep arrival order; target fill below training fill
		push_beat(OP_LOAD_TRAIN, 48'hA, 31'd5);
		push_beat(OP_LOAD_TRAIN, 48'hB, 31'd5);
		push_beat(OP_LOAD_TRAIN, 48'hC, 31'd9);
		push_beat(OP_LOAD_TRAIN, 48'hD, 31'd1);
		push_beat(OP_LOAD_TARGET, 48'hC, 31'd9);
		push_beat(OP_LOAD_TARGET, 48'hA, 31'd5);
		push_beat(OP_LOAD_TARGET, 48'hB, 31'd5);
		push_beat(OP_ANALYZE, '0, '0);
		// one side empty
		push_beat(OP_LOAD_TARGET, 48'hE, 31'd7);
		push_beat(OP_LOAD_TARGET, 48'hF, 31'd7);
		push_beat(OP_ANALYZE, '0, '0);
		push_beat(OP_LOAD_TRAIN, 48'hA, 31'd3);
		push_beat(OP_ANALYZE, '0, '0);
		// same entries, tied counts, opposite arrival order
		push_beat(OP_LOAD_TRAIN, 48'hA, 31'd2);
		push_beat(OP_LOAD_TRAIN, 48'hB, 31'd2);
		push_beat(OP_LOAD_TARGET, 48'hB, 31'd2);
		push_beat(OP_LOAD_TARGET, 48'hA, 31'd2);
		push_beat(OP_ANALYZE, '0, '0);

		wait_drained();

		// overfill both stores: evictions and drops at the tail, 256-rank compare
		queue_set(CAPACITY + 6, CAPACITY + 6, 1'b1, 1'b1);

		while (beats_queued < 700 || analyzes_queued < 40) begin
			if ($urandom_range(0, 7) == 0)
				wait_drained();
			queue_set($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 3) != 0,
				$urandom_range(0, 1));
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && due_totals.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
